>>> rtl/core/pdi_pkg.sv
// pdi_pkg: shared widths, register indexes, pattern codes and band table
// for the parking distance indicator. No dependencies.

package pdi_pkg;

  localparam int DISTANCE_WIDTH = 9;
  localparam int CFG_DIST_WIDTH = 9;
  localparam int HOLD_WIDTH     = 10;
  localparam int CFG_DATA_WIDTH = 10;
  localparam int CMP_WIDTH      = (DISTANCE_WIDTH > CFG_DIST_WIDTH) ? DISTANCE_WIDTH
                                                                    : CFG_DIST_WIDTH;
  localparam int NUM_BANDS      = 6;

  typedef logic [DISTANCE_WIDTH-1:0] distance_t;
  typedef logic [CMP_WIDTH-1:0]      cmp_t;
  typedef logic [HOLD_WIDTH-1:0]     count_t;
  typedef logic [3:0]                pattern_t;

  typedef enum logic [1:0] {
    REG_MIN_DISTANCE = 2'd0,
    REG_MAX_DISTANCE = 2'd1,
    REG_JUMP_LIMIT   = 2'd2,
    REG_HOLD_LIMIT   = 2'd3
  } cfg_reg_t;

  localparam pattern_t PAT_BLANK = 4'd0;
  localparam pattern_t PAT_ALERT = 4'd1;
  localparam pattern_t PAT_SMILE = 4'd2;
  localparam pattern_t PAT_ARROW = 4'd8;

  localparam count_t COUNT_MAX = {HOLD_WIDTH{1'b1}};

  localparam logic [7:0] ALERT_EDGE = 8'd2;
  localparam logic [7:0] BAND_EDGE [NUM_BANDS] = '{8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70};

  localparam logic [7:0] RESET_MIN_DISTANCE = 8'd0;
  localparam logic [7:0] RESET_MAX_DISTANCE = 8'd190;
  localparam logic [7:0] RESET_JUMP_LIMIT   = 8'd5;
  localparam logic [8:0] RESET_HOLD_LIMIT   = 9'd500;

  // fixed band pattern: smile below the first edge, then digits one..five
  function automatic pattern_t band_pattern(input distance_t d);
    pattern_t p;
    p = PAT_ARROW;
    for (int i = NUM_BANDS - 1; i >= 0; i--) begin
      if (d < DISTANCE_WIDTH'(BAND_EDGE[i])) begin
        p = PAT_SMILE + 4'(i);
      end
    end
    return p;
  endfunction

endpackage

>>> rtl/core/parking_distance_indicator.sv
// parking_distance_indicator: presence tracking, band pattern choice and
// stay timeout, one distance item per cycle unless stalled. Depends on pdi_pkg.
//
//  channel | signals                         | direction | handshake
//  in      | distance_cm                     | in        | in_valid / in_ready
//  out     | pattern, pattern_written,       | out       | out_valid / out_ready
//          | car_present, car_changed,       |           |
//          | timed_out                       |           |
//  cfg     | cfg_index, cfg_data             | in        | cfg_valid / cfg_ready
//
// An item is registered on accept and its result is loaded into the result
// register when the input stage advances, so one item per cycle is sustained
// while the output is not stalled; the state update for an item and the load
// of its result happen on the same edge.
// The input stage advances whenever the result register is empty or being
// taken, so a stalled output holds one result plus one waiting item.
// Synchronous reset restores register defaults and clears all non-data state.
// cfg_ready is always high.

module parking_distance_indicator
  import pdi_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [DISTANCE_WIDTH-1:0] distance_cm,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [3:0]                pattern,
  output logic                      pattern_written,
  output logic                      car_present,
  output logic                      car_changed,
  output logic                      timed_out,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  logic [CFG_DIST_WIDTH-1:0] near_limit;
  logic [CFG_DIST_WIDTH-1:0] far_limit;
  logic [CFG_DIST_WIDTH-1:0] jump_limit;
  count_t                    hold_limit;

  logic      s1_valid;
  distance_t s1_dist;
  logic      advance;

  distance_t previous_sample;
  pattern_t  shown_pattern;
  count_t    stay_count;
  logic      timeout_flag;
  logic      presence_flag;

  pattern_t  shown_pattern_next;
  count_t    stay_count_next;
  logic      timeout_flag_next;
  logic      presence_flag_next;
  logic      written_next;

  distance_t diff;
  cmp_t      d_cmp;
  logic      tmo_mid;
  pattern_t  target;
  logic      gate;
  logic      blank_band;
  pattern_t  pat_mid;
  count_t    cnt_mid;
  logic      wr_mid;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit <= CFG_DIST_WIDTH'(RESET_MIN_DISTANCE);
      far_limit  <= CFG_DIST_WIDTH'(RESET_MAX_DISTANCE);
      jump_limit <= CFG_DIST_WIDTH'(RESET_JUMP_LIMIT);
      hold_limit <= HOLD_WIDTH'(RESET_HOLD_LIMIT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_DISTANCE: near_limit <= cfg_data[CFG_DIST_WIDTH-1:0];
        REG_MAX_DISTANCE: far_limit  <= cfg_data[CFG_DIST_WIDTH-1:0];
        REG_JUMP_LIMIT:   jump_limit <= cfg_data[CFG_DIST_WIDTH-1:0];
        REG_HOLD_LIMIT:   hold_limit <= cfg_data[HOLD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_dist <= distance_cm;
    end
  end

  // single pass over the band order
  always_comb begin
    diff  = (s1_dist >= previous_sample) ? s1_dist - previous_sample
                                         : previous_sample - s1_dist;
    d_cmp = CMP_WIDTH'(s1_dist);

    tmo_mid = timeout_flag && !(CMP_WIDTH'(diff) > CMP_WIDTH'(jump_limit));
    presence_flag_next = (d_cmp > CMP_WIDTH'(near_limit)) &&
                         (d_cmp < CMP_WIDTH'(far_limit));

    blank_band = 1'b0;
    if (s1_dist == '0) begin
      target = PAT_BLANK;
      gate   = !tmo_mid;
    end else if (s1_dist < DISTANCE_WIDTH'(ALERT_EDGE)) begin
      target = PAT_ALERT;
      gate   = !tmo_mid;
    end else if (!tmo_mid &&
                 s1_dist < DISTANCE_WIDTH'(BAND_EDGE[NUM_BANDS-1])) begin
      target = band_pattern(s1_dist);
      gate   = 1'b1;
    end else if (d_cmp < CMP_WIDTH'(far_limit)) begin
      target = PAT_ARROW;
      gate   = !tmo_mid;
    end else begin
      target     = PAT_BLANK;
      gate       = 1'b1;
      blank_band = 1'b1;
    end

    pat_mid = shown_pattern;
    cnt_mid = stay_count;
    wr_mid  = 1'b0;
    if (shown_pattern != target && gate) begin
      pat_mid = target;
      wr_mid  = 1'b1;
      if (!blank_band) begin
        cnt_mid = '0;
      end
    end else if (!blank_band && stay_count != COUNT_MAX) begin
      cnt_mid = stay_count + count_t'(1);
    end

    shown_pattern_next = pat_mid;
    stay_count_next    = cnt_mid;
    timeout_flag_next  = tmo_mid;
    written_next       = wr_mid;
    if (cnt_mid > hold_limit) begin
      if (pat_mid != PAT_BLANK) begin
        shown_pattern_next = PAT_BLANK;
        timeout_flag_next  = 1'b1;
        written_next       = 1'b1;
      end
      stay_count_next = hold_limit + count_t'(1);
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      shown_pattern   <= PAT_BLANK;
      stay_count      <= '0;
      timeout_flag    <= 1'b0;
      presence_flag   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (advance) begin
        previous_sample <= s1_dist;
        shown_pattern   <= shown_pattern_next;
        stay_count      <= stay_count_next;
        timeout_flag    <= timeout_flag_next;
        presence_flag   <= presence_flag_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pattern         <= shown_pattern_next;
      pattern_written <= written_next;
      car_present     <= presence_flag_next;
      car_changed     <= presence_flag_next != presence_flag;
      timed_out       <= timeout_flag_next;
    end
  end

  // result register mirrors the state left by its item
  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pattern == shown_pattern) && (car_present == presence_flag) &&
                  (timed_out == timeout_flag))
    else $error("result register out of step with state");

  a_timeout_blank: assert property (@(posedge clk) disable iff (rst)
    timeout_flag |-> shown_pattern == PAT_BLANK)
    else $error("pattern shown while timed out");

  a_pattern_range: assert property (@(posedge clk) disable iff (rst)
    shown_pattern <= PAT_ARROW)
    else $error("pattern code out of range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    advance |=> car_changed == (presence_flag != $past(presence_flag)))
    else $error("presence change flag wrong");

endmodule
